// File: design/wrss_pkg.sv
package wrss_pkg;

  localparam int unsigned NCH   = 4;
  localparam int unsigned SW    = 32;
  localparam int unsigned MAXW  = 64;
  localparam int unsigned AW    = 6;
  localparam int unsigned CW    = 7;
  localparam int unsigned SYW   = 40;
  localparam int unsigned SXYW  = 48;
  localparam int unsigned DENW  = 13;
  localparam int unsigned NUMW  = 50;
  localparam int unsigned MW    = 48;
  localparam int unsigned DFW   = 52;
  localparam int unsigned QW    = 48;
  localparam int unsigned QCW   = 6;
  localparam int unsigned THRW  = 31;
  localparam int unsigned CFGW  = 31;
  localparam int unsigned CIDXW = 2;
  localparam int unsigned CHW   = 2;

  typedef enum logic [CIDXW-1:0] {
    REG_WINDOW    = 2'd0,
    REG_TRANS_THR = 2'd1,
    REG_ROT_THR   = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic load;
    logic slot;
    logic retire;
    logic write;
    logic ch_clr;
    logic mul;
    logic num;
    logic dev;
    logic div_start;
    logic div_step;
    logic store_raw;
    logic store_quo;
    logic ch_next;
    logic out_load;
  } wrss_cmd_t;

  typedef struct packed {
    logic full;
    logic pass;
    logic div_last;
    logic ch_last;
    logic out_free;
  } wrss_sts_t;

endpackage

// File: design/wrss_dp.sv
module wrss_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [wrss_pkg::CIDXW-1:0]        cfg_index_i,
  input  logic [wrss_pkg::CFGW-1:0]         cfg_data_i,
  input  logic signed [wrss_pkg::SW-1:0]    a_in_i,
  input  logic signed [wrss_pkg::SW-1:0]    b_in_i,
  input  logic signed [wrss_pkg::SW-1:0]    tx_in_i,
  input  logic signed [wrss_pkg::SW-1:0]    ty_in_i,
  input  logic                              out_stall_i,
  input  wrss_pkg::wrss_cmd_t               cmd_i,
  output wrss_pkg::wrss_sts_t               sts_o,
  output logic                              out_valid_o,
  output logic signed [wrss_pkg::SW-1:0]    a_out_o,
  output logic signed [wrss_pkg::SW-1:0]    b_out_o,
  output logic signed [wrss_pkg::SW-1:0]    tx_out_o,
  output logic signed [wrss_pkg::SW-1:0]    ty_out_o
);
  import wrss_pkg::*;

  localparam logic signed [QW:0] QMAX = {{(QW-SW+2){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [QW:0] QMIN = {{(QW-SW+2){1'b1}}, {(SW-1){1'b0}}};

  logic [CW-1:0]   win_q;
  logic [THRW-1:0] tthr_q, rthr_q;
  logic [CW-1:0]   w;
  logic [2*CW:0]   den_full;
  logic [DENW-1:0] den_q;

  logic signed [SW-1:0]   raw_q [NCH];
  logic signed [SYW-1:0]  sy_q  [NCH];
  logic signed [SXYW-1:0] sxy_q [NCH];
  logic signed [SW-1:0]   res_q [NCH];
  logic [CW-1:0]          fill_q;
  logic [AW-1:0]          oldest_q, slot_q;
  logic [AW+1:0]          sum_p;
  logic [AW-1:0]          slot_d;

  logic [NCH*SW-1:0] mem [MAXW];
  logic [NCH*SW-1:0] rdata_q;

  logic signed [SW+CW:0]  prod [NCH];
  logic signed [SYW-1:0]  sy_ret [NCH];

  logic [CHW-1:0]         ch_q;
  logic signed [CW:0]     nm2;
  logic signed [SXYW-1:0] p_d, p_q;
  logic signed [NUMW-1:0] sxy_e, p_e, num_d, num_q, nabs;
  logic signed [MW-1:0]   m1_q;
  logic [MW-1:0]          m2_q;
  logic [THRW-1:0]        thr;
  logic signed [DFW-1:0]  diff;
  logic [DFW-1:0]         absd;

  logic [QW-1:0]    quo_q;
  logic [DENW-1:0]  rem_q;
  logic [DENW:0]    trial, rem_n;
  logic             ge, neg_q;
  logic [QCW-1:0]   cnt_q;
  logic signed [QW:0] qs;
  logic [SW-1:0]    qsat;

  always_comb begin
    if (win_q == '0) begin
      w = CW'(1);
    end else if (win_q > CW'(MAXW)) begin
      w = CW'(MAXW);
    end else begin
      w = win_q;
    end
  end

  assign den_full = {{(CW+1){1'b0}}, w} * ({{(CW+1){1'b0}}, w} + (2*CW+1)'(1));
  assign sum_p    = {2'b00, oldest_q} + {1'b0, fill_q};

  always_comb begin
    if (sum_p >= {1'b0, w}) begin
      slot_d = AW'(sum_p - {1'b0, w});
    end else begin
      slot_d = sum_p[AW-1:0];
    end
  end

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      prod[c]   = $signed({1'b0, fill_q}) * raw_q[c];
      sy_ret[c] = sy_q[c] - SYW'($signed(rdata_q[c*SW +: SW]));
    end
  end

  assign nm2   = $signed({1'b0, w}) - (CW+1)'(2);
  assign p_d   = nm2 * sy_q[ch_q];
  assign sxy_e = NUMW'(sxy_q[ch_q]);
  assign p_e   = NUMW'(p_q);
  assign num_d = (sxy_e <<< 2) + (sxy_e <<< 1) - (p_e <<< 1);
  assign thr   = (ch_q < CHW'(2)) ? rthr_q : tthr_q;
  assign diff  = DFW'(m1_q) - DFW'(num_q);
  assign absd  = diff[DFW-1] ? DFW'(-diff) : DFW'(diff);
  assign nabs  = num_q[NUMW-1] ? -num_q : num_q;
  assign trial = {rem_q, quo_q[QW-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign rem_n = ge ? (trial - {1'b0, den_q}) : trial;
  assign qs    = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

  always_comb begin
    if (qs > QMAX) begin
      qsat = QMAX[SW-1:0];
    end else if (qs < QMIN) begin
      qsat = QMIN[SW-1:0];
    end else begin
      qsat = qs[SW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      mem[slot_q] <= {raw_q[3], raw_q[2], raw_q[1], raw_q[0]};
    end
    if (cmd_i.slot) begin
      rdata_q <= mem[oldest_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q    <= CW'(16);
      tthr_q   <= THRW'(65536);
      rthr_q   <= THRW'(32768);
      fill_q   <= '0;
      oldest_q <= '0;
      for (int c = 0; c < NCH; c++) begin
        sy_q[c]  <= '0;
        sxy_q[c] <= '0;
      end
    end else begin
      if (cmd_i.retire) begin
        for (int c = 0; c < NCH; c++) begin
          sy_q[c]  <= sy_ret[c];
          sxy_q[c] <= sxy_q[c] - SXYW'(sy_ret[c]);
        end
        oldest_q <= ({1'b0, slot_q} + CW'(1) == w) ? '0 : slot_q + AW'(1);
        fill_q   <= w - CW'(1);
      end
      if (cmd_i.write) begin
        for (int c = 0; c < NCH; c++) begin
          sy_q[c]  <= sy_q[c] + SYW'(raw_q[c]);
          sxy_q[c] <= sxy_q[c] + SXYW'(prod[c]);
        end
        fill_q <= fill_q + CW'(1);
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_WINDOW: begin
            win_q    <= cfg_data_i[CW-1:0];
            fill_q   <= '0;
            oldest_q <= '0;
            for (int c = 0; c < NCH; c++) begin
              sy_q[c]  <= '0;
              sxy_q[c] <= '0;
            end
          end
          REG_TRANS_THR: tthr_q <= cfg_data_i[THRW-1:0];
          REG_ROT_THR:   rthr_q <= cfg_data_i[THRW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      raw_q[0] <= a_in_i;
      raw_q[1] <= b_in_i;
      raw_q[2] <= tx_in_i;
      raw_q[3] <= ty_in_i;
    end
    if (cmd_i.slot) begin
      slot_q <= sts_o.full ? oldest_q : slot_d;
    end
    if (cmd_i.write) begin
      den_q <= den_full[DENW-1:0];
    end
    if (cmd_i.mul) begin
      p_q <= p_d;
    end
    if (cmd_i.num) begin
      num_q <= num_d;
    end
    if (cmd_i.dev) begin
      m1_q <= raw_q[ch_q] * $signed({1'b0, den_q});
      m2_q <= {{(MW-THRW){1'b0}}, thr} * {{(MW-DENW){1'b0}}, den_q};
    end
    if (cmd_i.div_start) begin
      neg_q <= num_q[NUMW-1];
      quo_q <= nabs[QW-1:0];
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[QW-2:0], ge};
      rem_q <= rem_n[DENW-1:0];
    end
    if (cmd_i.store_raw) begin
      res_q[ch_q] <= raw_q[ch_q];
    end
    if (cmd_i.store_quo) begin
      res_q[ch_q] <= qsat;
    end
    if (cmd_i.out_load) begin
      a_out_o  <= res_q[0];
      b_out_o  <= res_q[1];
      tx_out_o <= res_q[2];
      ty_out_o <= res_q[3];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q        <= '0;
      cnt_q       <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (cmd_i.ch_clr) begin
        ch_q <= '0;
      end else if (cmd_i.ch_next) begin
        ch_q <= ch_q + CHW'(1);
      end
      if (cmd_i.div_start) begin
        cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q + QCW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  assign sts_o.full     = fill_q >= w;
  assign sts_o.pass     = absd > {{(DFW-MW){1'b0}}, m2_q};
  assign sts_o.div_last = cnt_q == QCW'(QW-1);
  assign sts_o.ch_last  = ch_q == CHW'(NCH-1);
  assign sts_o.out_free = !out_valid_o || !out_stall_i;

endmodule

// File: design/wrss_ctrl.sv
module wrss_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  wrss_pkg::wrss_sts_t  sts_i,
  output wrss_pkg::wrss_cmd_t  cmd_o
);
  import wrss_pkg::*;

  typedef enum logic [12:0] {
    ST_IDLE = 13'b0000000000001,
    ST_SLOT = 13'b0000000000010,
    ST_RET  = 13'b0000000000100,
    ST_WR   = 13'b0000000001000,
    ST_CHK  = 13'b0000000010000,
    ST_MUL  = 13'b0000000100000,
    ST_NUM  = 13'b0000001000000,
    ST_DEV  = 13'b0000010000000,
    ST_CMP  = 13'b0000100000000,
    ST_DIV  = 13'b0001000000000,
    ST_FIN  = 13'b0010000000000,
    ST_NXT  = 13'b0100000000000,
    ST_OUT  = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SLOT;
        end
      end
      ST_SLOT: begin
        cmd_o.slot = 1'b1;
        state_d    = sts_i.full ? ST_RET : ST_WR;
      end
      ST_RET: begin
        cmd_o.retire = 1'b1;
        state_d      = ST_WR;
      end
      ST_WR: begin
        cmd_o.write = 1'b1;
        state_d     = ST_CHK;
      end
      ST_CHK: begin
        if (sts_i.full) begin
          cmd_o.ch_clr = 1'b1;
          state_d      = ST_MUL;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_NUM;
      end
      ST_NUM: begin
        cmd_o.num = 1'b1;
        state_d   = ST_DEV;
      end
      ST_DEV: begin
        cmd_o.dev = 1'b1;
        state_d   = ST_CMP;
      end
      ST_CMP: begin
        if (sts_i.pass) begin
          cmd_o.store_raw = 1'b1;
          state_d         = ST_NXT;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.store_quo = 1'b1;
        state_d         = ST_NXT;
      end
      ST_NXT: begin
        if (sts_i.ch_last) begin
          state_d = ST_OUT;
        end else begin
          cmd_o.ch_next = 1'b1;
          state_d       = ST_MUL;
        end
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = state_q != ST_IDLE;

endmodule

// File: design/window_regression_step_smoother.sv
// Sliding-window least-squares smoother for four Q16.16 motion channels (a, b, tx, ty).
// Each accepted item is written to a 64-entry sample memory and folded into running
// sums; once the window holds window_size samples every item gives one result: the
// fitted line's value at the newest sample, or the raw sample where it deviates from
// that value by more than the channel's threshold. While the window fills no result
// is given. An item that gives no result is loaded, placed in its slot and written;
// one with a result, which first retires the oldest sample if the window was already
// full, then works through the channels one after another, running the divider only for
// a channel whose smoothed value is taken, and it waits while an earlier result still
// sits stalled in the output register. The shared 48-step restoring divider is used
// one channel after another. Writing window_size empties the window. Results wait
// in an output register, so the next item is taken while a result is still stalled.
module window_regression_step_smoother (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [wrss_pkg::CIDXW-1:0]        cfg_index_i,
  input  logic [wrss_pkg::CFGW-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [wrss_pkg::SW-1:0]    a_in_i,
  input  logic signed [wrss_pkg::SW-1:0]    b_in_i,
  input  logic signed [wrss_pkg::SW-1:0]    tx_in_i,
  input  logic signed [wrss_pkg::SW-1:0]    ty_in_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [wrss_pkg::SW-1:0]    a_out_o,
  output logic signed [wrss_pkg::SW-1:0]    b_out_o,
  output logic signed [wrss_pkg::SW-1:0]    tx_out_o,
  output logic signed [wrss_pkg::SW-1:0]    ty_out_o
);
  import wrss_pkg::*;

  wrss_cmd_t cmd;
  wrss_sts_t sts;

  wrss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wrss_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .a_in_i      (a_in_i),
    .b_in_i      (b_in_i),
    .tx_in_i     (tx_in_i),
    .ty_in_i     (ty_in_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .a_out_o     (a_out_o),
    .b_out_o     (b_out_o),
    .tx_out_o    (tx_out_o),
    .ty_out_o    (ty_out_o)
  );

endmodule
